@@ hw/rtl/lrrxc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrxc_pkg
// Shared types, codes and helpers for the load record rotate-XOR checksum.
// ----------------------------------------------------------------------------
package lrrxc_pkg;

  localparam logic [3:0] MAX_DATA_WORDS = 4'd15;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_END     = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    CMD_M = 4'd0,
    CMD_I = 4'd1,
    CMD_O = 4'd2,
    CMD_N = 4'd3,
    CMD_L = 4'd4,
    CMD_Q = 4'd5,
    CMD_A = 4'd6,
    CMD_T = 4'd7,
    CMD_Z = 4'd8,
    CMD_G = 4'd9,
    CMD_H = 4'd10,
    CMD_C = 4'd11,
    CMD_B = 4'd12,
    CMD_P = 4'd13
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_ILLEGAL   = 2'd1,
    ERR_TOO_MANY  = 2'd2,
    ERR_NO_RECORD = 2'd3
  } err_t;

  // Decoded header: starting code of the record and illegal-command flag.
  typedef struct packed {
    logic [15:0] code;
    logic        bad;
  } hdr_t;

  function automatic logic [15:0] rot1(input logic [15:0] v);
    rot1 = {v[14:0], v[15]};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lrrxc_hdr_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrxc_hdr_decode
// Turn a header command and address into the record's starting code.
// ----------------------------------------------------------------------------
module lrrxc_hdr_decode
  import lrrxc_pkg::*;
(
  input  wire logic [3:0]  command,
  input  wire logic [19:0] address,
  output hdr_t             hdr
);

  logic [4:0]  base;
  logic        use_addr;
  logic        rot_hi;
  logic        bad;
  logic [15:0] shifted;
  logic [15:0] mixed;

  always_comb begin
    base     = 5'd0;
    use_addr = 1'b1;
    rot_hi   = 1'b0;
    bad      = 1'b0;
    unique case (command)
      CMD_M: begin
        base   = 5'h9;
        rot_hi = 1'b1;
      end
      CMD_I, CMD_O: base = 5'h9;
      CMD_N: base = 5'hA;
      // operand select: address bits 7:4 add to the base
      CMD_L: base = 5'hA + {1'b0, address[7:4]};
      CMD_Q: base = 5'hB;
      CMD_A: begin
        base     = 5'h6;
        use_addr = 1'b0;
      end
      CMD_T: begin
        base   = 5'h6;
        rot_hi = 1'b1;
      end
      CMD_Z: begin
        base     = 5'h8;
        use_addr = 1'b0;
      end
      CMD_G, CMD_H: base = 5'h8;
      CMD_C: begin
        base   = 5'hE;
        rot_hi = 1'b1;
      end
      CMD_B, CMD_P: base = 5'hE;
      default: begin
        bad      = 1'b1;
        use_addr = 1'b0;
      end
    endcase
  end

  assign shifted = {10'd0, base, 1'b0};
  assign mixed   = shifted ^ address[15:0];

  always_comb begin
    hdr.bad = bad;
    if (!use_addr) begin
      hdr.code = shifted;
    end else if (rot_hi) begin
      hdr.code = rot1(mixed) ^ {12'd0, address[19:16]};
    end else begin
      hdr.code = mixed;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/load_record_rotate_xor_checksum_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// out_valid rises after the word passes the input register and then the result register.
// Throughput: one word per cycle unless a result waits on out_ready; checksums are registered.
// Headers, data words and restarts produce no result unless they hit an error.
// Reset (rst_n low, synchronous) empties both stages and clears all checksum state.
// ----------------------------------------------------------------------------
// load_record_rotate_xor_checksum_top
// Per-record and running rotate-left XOR checksums over load-module records.
// ----------------------------------------------------------------------------
module load_record_rotate_xor_checksum_top
  import lrrxc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [3:0]  in_command,
  input  wire logic [19:0] in_address,
  input  wire logic [15:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_line_checksum,
  output logic [15:0]      out_global_checksum,
  output logic [3:0]       out_word_count,
  output logic [1:0]       out_error_code
);

  // Input stage: holds one accepted word.
  logic        s1_valid_r;
  logic [1:0]  s1_kind_r;
  logic [3:0]  s1_command_r;
  logic [19:0] s1_address_r;
  logic [15:0] s1_data_word_r;

  // Checksum state.
  logic [15:0] record_code_r, record_code_nxt;
  logic [3:0]  words_seen_r, words_seen_nxt;
  logic        record_open_r, record_open_nxt;
  logic        record_bad_r, record_bad_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic        sum_started_r, sum_started_nxt;

  // Result stage.
  logic        out_valid_r;
  logic [15:0] out_line_r;
  logic [15:0] out_global_r;
  logic [3:0]  out_count_r;
  logic [1:0]  out_err_r;

  logic        emit_nxt;
  logic [15:0] line_nxt;
  logic [3:0]  count_nxt;
  err_t        err_nxt;

  logic slot_free;
  logic s1_fire;
  hdr_t hdr;

  // The result slot takes a new word when empty or draining this cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && slot_free;
  assign in_ready  = !s1_valid_r || slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r      <= in_kind;
      s1_command_r   <= in_command;
      s1_address_r   <= in_address;
      s1_data_word_r <= in_data_word;
    end
  end

  lrrxc_hdr_decode u_hdr_decode (
    .command (s1_command_r),
    .address (s1_address_r),
    .hdr     (hdr)
  );

  // Process the staged word against the checksum state.
  always_comb begin
    record_code_nxt = record_code_r;
    words_seen_nxt  = words_seen_r;
    record_open_nxt = record_open_r;
    record_bad_nxt  = record_bad_r;
    running_sum_nxt = running_sum_r;
    sum_started_nxt = sum_started_r;
    emit_nxt        = 1'b0;
    line_nxt        = 16'd0;
    count_nxt       = 4'd0;
    err_nxt         = ERR_OK;
    if (s1_fire) begin
      unique case (kind_t'(s1_kind_r))
        KIND_HEADER: begin
          // A header abandons any open record and starts a fresh one.
          record_code_nxt = hdr.code;
          words_seen_nxt  = 4'd0;
          record_open_nxt = 1'b1;
          record_bad_nxt  = hdr.bad;
          if (hdr.bad) begin
            emit_nxt = 1'b1;
            err_nxt  = ERR_ILLEGAL;
          end
        end
        KIND_DATA: begin
          if (!record_open_r) begin
            emit_nxt = 1'b1;
            err_nxt  = ERR_NO_RECORD;
          end else if (words_seen_r >= MAX_DATA_WORDS) begin
            // Drop the word; the record stays open.
            emit_nxt  = 1'b1;
            count_nxt = words_seen_r;
            err_nxt   = ERR_TOO_MANY;
          end else begin
            record_code_nxt = rot1(record_code_r) ^ s1_data_word_r;
            words_seen_nxt  = 4'(words_seen_r + 4'd1);
          end
        end
        KIND_END: begin
          if (!record_open_r) begin
            emit_nxt = 1'b1;
            err_nxt  = ERR_NO_RECORD;
          end else begin
            emit_nxt        = 1'b1;
            count_nxt       = words_seen_r;
            record_open_nxt = 1'b0;
            words_seen_nxt  = 4'd0;
            if (record_bad_r) begin
              // Bad record: report again, leave the global sum alone.
              record_bad_nxt = 1'b0;
              err_nxt        = ERR_ILLEGAL;
            end else begin
              line_nxt        = record_code_r;
              running_sum_nxt = sum_started_r ? (rot1(running_sum_r) ^ record_code_r)
                                              : rot1(record_code_r);
              sum_started_nxt = 1'b1;
            end
          end
        end
        KIND_RESTART: begin
          running_sum_nxt = 16'd0;
          sum_started_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_code_r <= 16'd0;
      words_seen_r  <= 4'd0;
      record_open_r <= 1'b0;
      record_bad_r  <= 1'b0;
      running_sum_r <= 16'd0;
      sum_started_r <= 1'b0;
    end else begin
      record_code_r <= record_code_nxt;
      words_seen_r  <= words_seen_nxt;
      record_open_r <= record_open_nxt;
      record_bad_r  <= record_bad_nxt;
      running_sum_r <= running_sum_nxt;
      sum_started_r <= sum_started_nxt;
    end
  end

  // Result register: drain on out_ready, load when a word produces a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= emit_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit_nxt) begin
      out_line_r   <= line_nxt;
      out_global_r <= running_sum_nxt;
      out_count_r  <= count_nxt;
      out_err_r    <= err_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_checksum   = out_line_r;
  assign out_global_checksum = out_global_r;
  assign out_word_count      = out_count_r;
  assign out_error_code      = out_err_r;

  // Word count never runs past the record limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    words_seen_r <= MAX_DATA_WORDS)
    else $error("words_seen_r exceeds record limit");

  // A closed record carries no count and no bad flag.
  a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !record_open_r |-> (words_seen_r == 4'd0 && !record_bad_r))
    else $error("closed record holds stale count or bad flag");

  // A restart leaves the global sum cleared.
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_kind_r == KIND_RESTART) |=> (running_sum_r == 16'd0 && !sum_started_r))
    else $error("restart did not clear global checksum");

  // Error results carry a zero line checksum.
  a_err_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_OK) |-> (out_line_r == 16'd0))
    else $error("error result with nonzero line checksum");

endmodule
`default_nettype wire
